@@ hw/rtl/ita_pkg.sv @@
// Shared types, constants and a helper function for the integer-to-ASCII formatter.
package ita_pkg;

    localparam int NCELL   = 16;
    localparam int DIGIT_W = 4;
    localparam int BIN_W   = 32;
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 5;

    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEXL = 2'd2;
    localparam logic [1:0] OP_HEXU = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_LOWER  = 8'h57;
    localparam logic [CHAR_W-1:0] CHAR_UPPER  = 8'h37;

    localparam logic [CNT_W-1:0] STEP_LAST  = CNT_W'(BIN_W - 1);
    localparam logic [CNT_W-1:0] DIGITS_ALL = CNT_W'(NCELL);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input digit_t d, input logic upper);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < 4'd10)
        begin
            return CHAR_ZERO + wide;
        end
        else if (upper)
        begin
            return CHAR_UPPER + wide;
        end
        else
        begin
            return CHAR_LOWER + wide;
        end
    endfunction

endpackage

@@ hw/rtl/ita_if.sv @@
// Valid/ready stream interfaces for the formatter's input items and output characters.
interface ita_in_if;
    import ita_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [1:0]         opcode;

    modport source (output valid, output value, output opcode, input ready);
    modport sink (input valid, input value, input opcode, output ready);
endinterface

interface ita_out_if;
    import ita_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink (input valid, input char_out, input last, output ready);
endinterface

@@ hw/rtl/integer_to_ascii_formatter.sv @@
// Top level of the integer-to-ASCII formatter: control sequencer, digit cell row, output register.
//
// The item channel takes a 64-bit value and a 2-bit opcode (signed decimal, unsigned
// decimal on the low 32 bits, lower-case hex, upper-case hex). The chars channel
// returns the ASCII text of the value one character per transfer, most significant
// digit first, with no leading zeros and last set on the final character.
// The block works on one item at a time; item.ready is high only while it is idle.
// A decimal item goes through the double-dabble conversion in the row of 16 digit
// cells, the sign state if negative, then the skip phase, which shifts out leading
// zero cells, and then the emit phase, which sends one character per transfer.
// A hex item loads the cells directly and goes straight to the skip phase. The
// 16-cell shift row sets the skip and emit length.
// Characters sit in an output register; while the receiver holds chars.ready low the
// character stays there and the sequencer waits. The next item may be accepted the
// cycle after the final character has been loaded into the output register.
// Reset clears the sequencer and the output valid flag; the block is then idle.
module integer_to_ascii_formatter
    import ita_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ita_in_if.sink    item,
    ita_out_if.source chars
);

    state_t state_reg;
    state_t state_next;

    logic [BIN_W-1:0]  mag_reg;
    logic [BIN_W-1:0]  mag_next;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  step_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic              neg_reg;
    logic              neg_next;
    logic              upper_reg;
    logic              upper_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic [CHAR_W-1:0] out_char_next;
    logic              out_last_reg;
    logic              out_last_next;

    cell_ctrl_t        ctrl;
    logic              out_free;
    logic              accept;
    logic [BIN_W-1:0]  low_word;
    logic              is_neg;

    digit_t            digits [NCELL];
    digit_t            load_digits [NCELL];
    logic              carry [NCELL+1];
    digit_t            top_digit;

    assign out_free   = !out_valid_reg || chars.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign low_word   = item.value[BIN_W-1:0];
    assign is_neg     = (item.opcode == OP_SDEC) && low_word[BIN_W-1];
    assign top_digit  = digits[NCELL-1];
    assign carry[0]   = mag_reg[BIN_W-1];

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            assign load_digits[gi] = item.opcode[1] ? item.value[gi*DIGIT_W +: DIGIT_W]
                                                    : '0;
            ita_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .load_digit (load_digits[gi]),
                .bit_in     (carry[gi]),
                .digit_in   ((gi == 0) ? digit_t'(0) : digits[(gi == 0) ? 0 : gi-1]),
                .bit_out    (carry[gi+1]),
                .digit      (digits[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg && !chars.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load  = 1'b1;
                    neg_next   = is_neg;
                    upper_next = (item.opcode == OP_HEXU);
                    mag_next   = is_neg ? (BIN_W'(0) - low_word) : low_word;
                    step_next  = STEP_LAST;
                    rem_next   = DIGITS_ALL;
                    state_next = item.opcode[1] ? ST_SKIP : ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.dabble = 1'b1;
                mag_next    = {mag_reg[BIN_W-2:0], 1'b0};
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == '0) && (rem_reg != CNT_W'(1)))
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.shift     = 1'b1;
                    out_valid_next = 1'b1;
                    out_char_next  = digit_to_ascii(top_digit, upper_reg);
                    out_last_next  = (rem_reg == CNT_W'(1));
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        step_reg     <= step_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        upper_reg    <= upper_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign chars.valid    = out_valid_reg;
    assign chars.char_out = out_char_reg;
    assign chars.last     = out_last_reg;

endmodule

@@ hw/rtl/ita_cell.sv @@
// One digit cell: double-dabble step, parallel load and nibble shift toward its upper neighbor.
module ita_cell
    import ita_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  digit_t     load_digit,
    input  logic       bit_in,
    input  digit_t     digit_in,
    output logic       bit_out,
    output digit_t     digit
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t corr;

    always_comb
    begin
        corr = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        digit_next = digit_reg;
        if (ctrl.load)
        begin
            digit_next = load_digit;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {corr[DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign bit_out = corr[DIGIT_W-1];
    assign digit   = digit_reg;

endmodule

@@ dv/tb_integer_to_ascii_formatter.sv @@
// Self-checking testbench for the integer-to-ASCII formatter with randomized handshakes.
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter;
    import ita_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          TAIL_CYCLES   = 64;
    localparam int          RANDOM_PER_PH = 97;
    localparam logic [7:0]  ASCII_ZERO    = 8'h30;
    localparam logic [7:0]  ASCII_MINUS   = 8'h2d;
    localparam logic [7:0]  ASCII_LOWER_A = 8'h61;
    localparam logic [7:0]  ASCII_UPPER_A = 8'h41;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  opcode;
        bit          drain;
    } number_item_t;

    logic clk;
    logic rst_n;

    ita_in_if  item_if ();
    ita_out_if chars_if ();

    integer_to_ascii_formatter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .chars (chars_if)
    );

    number_item_t number_queue[$];
    text_char_t   awaited_chars[$];
    int           items_sent;
    int           items_accepted;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           error_count;
    int           cycle_count;

    function automatic void format_ascii(input logic [63:0] value, input logic [1:0] opcode);
        logic [31:0] word;
        logic [31:0] mag32;
        logic [63:0] mag64;
        logic [7:0]  nib;
        logic [7:0]  text[$];
        logic        negative;
        text_char_t  entry;
        word = value[31:0];
        negative = 1'b0;
        if (opcode == OP_SDEC || opcode == OP_UDEC)
        begin
            negative = (opcode == OP_SDEC) && word[31];
            mag32 = negative ? (32'd0 - word) : word;
            do
            begin
                text.push_front(ASCII_ZERO + 8'(mag32 % 10));
                mag32 = mag32 / 10;
            end
            while (mag32 != 0);
            if (negative)
            begin
                text.push_front(ASCII_MINUS);
            end
        end
        else
        begin
            mag64 = value;
            do
            begin
                nib = {4'd0, mag64[3:0]};
                if (nib < 8'd10)
                begin
                    text.push_front(ASCII_ZERO + nib);
                end
                else if (opcode == OP_HEXU)
                begin
                    text.push_front(ASCII_UPPER_A + nib - 8'd10);
                end
                else
                begin
                    text.push_front(ASCII_LOWER_A + nib - 8'd10);
                end
                mag64 = mag64 >> 4;
            end
            while (mag64 != 0);
        end
        for (int k = 0; k < text.size(); k++)
        begin
            entry.code = text[k];
            entry.last = (k == text.size() - 1);
            awaited_chars.push_back(entry);
        end
    endfunction

    function automatic void add_number(input logic [63:0] value, input logic [1:0] opcode,
                                       input bit drain);
        number_item_t it;
        it.value  = value;
        it.opcode = opcode;
        it.drain  = drain;
        number_queue.push_back(it);
    endfunction

    function automatic void add_random_numbers(input int count);
        logic [63:0] value;
        int          nbits;
        for (int i = 0; i < count; i++)
        begin
            value = {$urandom, $urandom};
            nbits = $urandom_range(64, 0);
            if (nbits < 64)
            begin
                value = value & ((64'd1 << nbits) - 64'd1);
            end
            if ($urandom_range(19, 0) == 0)
            begin
                value[31:0] = 32'h8000_0000;
            end
            add_number(value, 2'($urandom_range(3, 0)), i == count / 2);
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_integer_to_ascii_formatter: errors");
            $finish;
        end
    end

    // Item driver and chars.ready randomizer: holds a presented item until its transfer has happened.
    always @(negedge clk)
    begin
        chars_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        if (!(item_if.valid && items_accepted < items_sent))
        begin
            if (number_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct &&
                (!number_queue[0].drain || awaited_chars.size() == 0))
            begin
                item_if.valid  <= 1'b1;
                item_if.value  <= number_queue[0].value;
                item_if.opcode <= number_queue[0].opcode;
                void'(number_queue.pop_front());
                items_sent++;
            end
            else
            begin
                item_if.valid  <= 1'b0;
                item_if.value  <= {$urandom, $urandom};
                item_if.opcode <= 2'($urandom_range(3, 0));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_if.valid && item_if.ready)
        begin
            format_ascii(item_if.value, item_if.opcode);
            items_accepted++;
        end
    end

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            if (awaited_chars.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                         $time, chars_if.char_out, chars_if.last);
            end
            else
            begin
                want = awaited_chars.pop_front();
                if (chars_if.char_out !== want.code)
                begin
                    error_count++;
                    $display("%0t: char_out mismatch, expected %h, actual %h",
                             $time, want.code, chars_if.char_out);
                end
                if (chars_if.last !== want.last)
                begin
                    error_count++;
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, want.last, chars_if.last);
                end
            end
        end
    end

    initial
    begin
        item_if.valid  = 1'b0;
        item_if.value  = '0;
        item_if.opcode = OP_SDEC;
        chars_if.ready = 1'b0;
        items_sent     = 0;
        items_accepted = 0;
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 20;
        recv_idle_pct  = 76;
        rst_n          = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_number(64'd0, OP_SDEC, 0);
        add_number(64'd0, OP_UDEC, 0);
        add_number(64'd0, OP_HEXL, 0);
        add_number(64'd0, OP_HEXU, 0);
        add_number(64'h0000_0000_8000_0000, OP_SDEC, 0);
        add_number(64'hFFFF_FFFF_8000_0000, OP_SDEC, 0);
        add_number(64'h0000_0000_7FFF_FFFF, OP_SDEC, 0);
        add_number(64'h0000_0000_FFFF_FFFF, OP_SDEC, 0);
        add_number(64'hDEAD_BEEF_0000_007B, OP_SDEC, 0);
        add_number(64'h0000_0000_0000_0001, OP_SDEC, 1);
        add_number(64'h0000_0000_FFFF_FFFF, OP_UDEC, 0);
        add_number(64'hFFFF_FFFF_0000_0000, OP_UDEC, 0);
        add_number(64'h0000_0000_8000_0000, OP_UDEC, 0);
        add_number(64'h1234_5678_0000_0009, OP_UDEC, 0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, OP_HEXL, 0);
        add_number(64'hFEDC_BA98_7654_3210, OP_HEXL, 0);
        add_number(64'h0123_4567_89AB_CDEF, OP_HEXU, 0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, OP_HEXU, 0);
        add_number(64'h0000_0000_0000_000A, OP_HEXU, 0);
        add_number(64'h8000_0000_0000_0000, OP_HEXL, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 20;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            add_random_numbers(RANDOM_PER_PH);
            while (number_queue.size() != 0 || items_accepted != items_sent)
            begin
                @(posedge clk);
            end
        end

        while (awaited_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb_integer_to_ascii_formatter: clean");
        end
        else
        begin
            $display("tb_integer_to_ascii_formatter: errors");
        end
        $finish;
    end

endmodule
